[rtl/lsd_radix_sort_linked_bins_unit_assert.svh]
// Assertion macros shared by the radix sort RTL.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef LSD_RADIX_SORT_LINKED_BINS_UNIT_ASSERT_SVH
`define LSD_RADIX_SORT_LINKED_BINS_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define LSDR_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define LSDR_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/lsdr_pkg.sv]
// Package for the linked-bin radix sort: field widths, decimal constants, state type.
// No dependencies.
`default_nettype none

package lsdr_pkg;

    localparam int KEY_W   = 16;
    localparam int POS_W   = 7;
    localparam int PASS_W  = 3;
    localparam int DIGIT_W = 4;
    localparam int RADIX   = 10;

    localparam logic [DIGIT_W-1:0] TOP_BIN      = 4'd9;
    localparam logic [PASS_W-1:0]  PASSES_RESET = 3'd4;

    // x / 10 == (x * 0xCCCD) >> 19 for every x below 2**16.
    localparam logic [15:0] DIV10_MUL   = 16'hCCCD;
    localparam int          DIV10_SHIFT = 19;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_DIST_RD,
        ST_DIST_MUL,
        ST_DIST_BIN,
        ST_JOIN,
        ST_TERM,
        ST_OUT_RD,
        ST_OUT_SHOW
    } state_t;

endpackage

`default_nettype wire

[rtl/lsdr_key_if.sv]
// Input request channel of the radix sort: one key and its last-of-set mark.
// Depends on lsdr_pkg.
`default_nettype none

interface lsdr_key_if;
    logic                       valid;
    logic                       ready;
    logic [lsdr_pkg::KEY_W-1:0] key_value;
    logic                       last_key;

    modport source (output valid, key_value, last_key, input ready);
    modport sink   (input valid, key_value, last_key, output ready);
endinterface

`default_nettype wire

[rtl/lsdr_result_if.sv]
// Result request channel of the radix sort: sorted key, load position, end mark.
// Depends on lsdr_pkg.
`default_nettype none

interface lsdr_result_if;
    logic                       valid;
    logic                       ready;
    logic [lsdr_pkg::KEY_W-1:0] sorted_key;
    logic [lsdr_pkg::POS_W-1:0] source_position;
    logic                       final_result;

    modport source (output valid, sorted_key, source_position, final_result, input ready);
    modport sink   (input valid, sorted_key, source_position, final_result, output ready);
endinterface

`default_nettype wire

[rtl/lsd_radix_sort_linked_bins_unit.sv]
// Top level of the LSD decimal radix sort over a linked key store.
// Depends on lsdr_pkg, lsdr_key_if, lsdr_result_if, lsdr_digit_unit and the assert header.
//
//   channel   | dir | handshake       | payload
//   ----------+-----+-----------------+------------------------------------------
//   keys      | in  | valid / ready   | key_value[15:0], last_key
//   results   | out | valid / ready   | sorted_key[15:0], source_position[6:0],
//             |     |                 | final_result
//   cfg       | in  | cfg_wen         | cfg_wdata[2:0] = digit_passes
//
// Keys load one per cycle while idle. The request marked last starts the sort: in each
// pass the digit unit and the link memory see each key in the read, multiply and bin
// states, then ten bins are rejoined. Each result then passes a link/key memory read
// state and an output state, which holds while results stall. Reset is asynchronous
// and needs no clearing pass. The block does not take a request from the sort start
// until the final result is accepted.
`default_nettype none

`include "lsd_radix_sort_linked_bins_unit_assert.svh"

module lsd_radix_sort_linked_bins_unit #(
    parameter int MAX_ITEMS = 64,
    parameter int KEY_BITS  = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wen,
    input  wire logic [lsdr_pkg::PASS_W-1:0]   cfg_wdata,
    lsdr_key_if.sink                           keys,
    lsdr_result_if.source                      results
);

    localparam int IW = $clog2(MAX_ITEMS + 1);
    localparam int SB = (KEY_BITS < lsdr_pkg::KEY_W) ? KEY_BITS : lsdr_pkg::KEY_W;
    localparam int DW = lsdr_pkg::DIGIT_W;

    lsdr_pkg::state_t state_reg, state_next;

    logic [IW-1:0]                 count_reg;
    logic [lsdr_pkg::PASS_W-1:0]   passes_reg;
    logic [lsdr_pkg::PASS_W-1:0]   pass_reg;
    logic [lsdr_pkg::RADIX-1:0]    front_vld_reg;
    logic                          have_head_reg;
    logic [DW-1:0]                 bin_reg;
    logic [IW-1:0]                 k_reg;
    logic [IW-1:0]                 cur_reg;
    logic [IW-1:0]                 head_reg;
    logic [IW-1:0]                 last_reg;
    logic [IW-1:0]                 front_reg [lsdr_pkg::RADIX];
    logic [IW-1:0]                 rear_reg  [lsdr_pkg::RADIX];

    logic [SB-1:0]                 key_mem  [MAX_ITEMS + 1];
    logic [SB-1:0]                 quot_mem [MAX_ITEMS + 1];
    logic [IW-1:0]                 link_mem [MAX_ITEMS + 1];
    logic [SB-1:0]                 key_rd;
    logic [SB-1:0]                 quot_rd;
    logic [IW-1:0]                 link_rd;

    logic                          key_acc;
    logic                          store_en;
    logic                          out_acc;
    logic                          is_final;
    logic                          last_pass;
    logic                          link_we;
    logic [IW-1:0]                 link_wa;
    logic [IW-1:0]                 link_wd;
    logic [IW-1:0]                 load_pos;

    logic [SB-1:0]                 unit_quot;
    logic [DW-1:0]                 dig;

    lsdr_digit_unit #(
        .XW (SB)
    ) u_digit (
        .clk   (clk),
        .en    (state_reg == lsdr_pkg::ST_DIST_MUL),
        .x     (quot_rd),
        .quot  (unit_quot),
        .digit (dig)
    );

    assign key_acc   = keys.valid && keys.ready;
    assign store_en  = key_acc && (count_reg < IW'(MAX_ITEMS));
    assign load_pos  = count_reg + 1'b1;
    assign out_acc   = results.valid && results.ready;
    assign is_final  = (k_reg + 1'b1) == count_reg;
    assign last_pass = (pass_reg + 1'b1) == passes_reg;

    assign results.sorted_key      = lsdr_pkg::KEY_W'(key_rd);
    assign results.source_position = lsdr_pkg::POS_W'(cur_reg);
    assign results.final_result    = is_final;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= lsdr_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        keys.ready    = 1'b0;
        results.valid = 1'b0;
        link_we       = 1'b0;
        link_wa       = '0;
        link_wd       = '0;
        unique case (state_reg)
            lsdr_pkg::ST_IDLE:
            begin
                keys.ready = 1'b1;
                // Links are prethreaded in load order; the sort start terminates the list.
                link_we    = store_en;
                link_wa    = load_pos;
                link_wd    = count_reg + IW'(2);
                if (key_acc && keys.last_key)
                    state_next = lsdr_pkg::ST_INIT;
            end
            lsdr_pkg::ST_INIT:
            begin
                link_we    = 1'b1;
                link_wa    = count_reg;
                link_wd    = '0;
                state_next = (passes_reg == '0) ? lsdr_pkg::ST_OUT_RD : lsdr_pkg::ST_DIST_RD;
            end
            lsdr_pkg::ST_DIST_RD:
                state_next = lsdr_pkg::ST_DIST_MUL;
            lsdr_pkg::ST_DIST_MUL:
                state_next = lsdr_pkg::ST_DIST_BIN;
            lsdr_pkg::ST_DIST_BIN:
            begin
                link_we    = front_vld_reg[dig];
                link_wa    = rear_reg[dig];
                link_wd    = cur_reg;
                state_next = (link_rd == '0) ? lsdr_pkg::ST_JOIN : lsdr_pkg::ST_DIST_RD;
            end
            lsdr_pkg::ST_JOIN:
            begin
                link_we    = front_vld_reg[bin_reg] && have_head_reg;
                link_wa    = last_reg;
                link_wd    = front_reg[bin_reg];
                state_next = (bin_reg == '0) ? lsdr_pkg::ST_TERM : lsdr_pkg::ST_JOIN;
            end
            lsdr_pkg::ST_TERM:
            begin
                link_we    = 1'b1;
                link_wa    = last_reg;
                link_wd    = '0;
                state_next = last_pass ? lsdr_pkg::ST_OUT_RD : lsdr_pkg::ST_DIST_RD;
            end
            lsdr_pkg::ST_OUT_RD:
                state_next = lsdr_pkg::ST_OUT_SHOW;
            lsdr_pkg::ST_OUT_SHOW:
            begin
                results.valid = 1'b1;
                if (results.ready)
                    state_next = is_final ? lsdr_pkg::ST_IDLE : lsdr_pkg::ST_OUT_RD;
            end
            default:
                state_next = lsdr_pkg::ST_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            passes_reg    <= lsdr_pkg::PASSES_RESET;
            pass_reg      <= '0;
            front_vld_reg <= '0;
            have_head_reg <= 1'b0;
            bin_reg       <= '0;
            k_reg         <= '0;
            cur_reg       <= '0;
            head_reg      <= IW'(1);
        end
        else
        begin
            if (cfg_wen)
                passes_reg <= cfg_wdata;
            unique case (state_reg)
                lsdr_pkg::ST_IDLE:
                begin
                    if (store_en)
                        count_reg <= load_pos;
                end
                lsdr_pkg::ST_INIT:
                begin
                    head_reg      <= IW'(1);
                    cur_reg       <= IW'(1);
                    pass_reg      <= '0;
                    k_reg         <= '0;
                    front_vld_reg <= '0;
                end
                lsdr_pkg::ST_DIST_BIN:
                begin
                    front_vld_reg[dig] <= 1'b1;
                    cur_reg            <= link_rd;
                    bin_reg            <= lsdr_pkg::TOP_BIN;
                    have_head_reg      <= 1'b0;
                end
                lsdr_pkg::ST_JOIN:
                begin
                    if (front_vld_reg[bin_reg])
                    begin
                        have_head_reg <= 1'b1;
                        if (!have_head_reg)
                            head_reg <= front_reg[bin_reg];
                    end
                    bin_reg <= bin_reg - 1'b1;
                end
                lsdr_pkg::ST_TERM:
                begin
                    front_vld_reg <= '0;
                    pass_reg      <= pass_reg + 1'b1;
                    cur_reg       <= head_reg;
                    k_reg         <= '0;
                end
                lsdr_pkg::ST_OUT_SHOW:
                begin
                    if (out_acc)
                    begin
                        cur_reg <= link_rd;
                        k_reg   <= k_reg + 1'b1;
                        if (is_final)
                            count_reg <= '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Bin tables and the tail pointer of the list being rejoined.
    always_ff @(posedge clk)
    begin
        if (state_reg == lsdr_pkg::ST_DIST_BIN)
        begin
            if (!front_vld_reg[dig])
                front_reg[dig] <= cur_reg;
            rear_reg[dig] <= cur_reg;
        end
        if (state_reg == lsdr_pkg::ST_JOIN && front_vld_reg[bin_reg])
            last_reg <= rear_reg[bin_reg];
    end

    // Store memories: one write port each, read registered at the walk pointer.
    always_ff @(posedge clk)
    begin
        if (store_en)
            key_mem[load_pos] <= keys.key_value[SB-1:0];
        if (store_en)
            quot_mem[load_pos] <= keys.key_value[SB-1:0];
        else if (state_reg == lsdr_pkg::ST_DIST_BIN)
            quot_mem[cur_reg] <= unit_quot;
        if (link_we)
            link_mem[link_wa] <= link_wd;
        key_rd  <= key_mem[cur_reg];
        quot_rd <= quot_mem[cur_reg];
        link_rd <= link_mem[cur_reg];
    end

    `LSDR_ASSERT_IMPL(a_ready_excludes_output, keys.ready, !results.valid, "input ready while emitting results")
    `LSDR_ASSERT_IMPL(a_count_bound, 1'b1, count_reg <= IW'(MAX_ITEMS), "load count above capacity")
    `LSDR_ASSERT_NEXT(a_final_returns_idle, out_acc && results.final_result, keys.ready, "no return to loading after the final result")
    `LSDR_ASSERT_IMPL(a_walk_pointer_live, state_reg == lsdr_pkg::ST_DIST_RD || state_reg == lsdr_pkg::ST_OUT_RD, cur_reg != '0, "list walk reached the end marker")

endmodule

`default_nettype wire

[rtl/lsdr_digit_unit.sv]
// Shared decimal digit unit: splits a value into value/10 and value%10.
// One registered reciprocal multiply; results are valid the cycle after en. Uses lsdr_pkg.
`default_nettype none

module lsdr_digit_unit #(
    parameter int XW = 16
) (
    input  wire logic                         clk,
    input  wire logic                         en,
    input  wire logic [XW-1:0]                x,
    output logic      [XW-1:0]                quot,
    output logic      [lsdr_pkg::DIGIT_W-1:0] digit
);

    localparam int PW = XW + 16;

    logic [XW-1:0] x_reg;
    logic [PW-1:0] prod_reg;
    logic [XW+3:0] rem_wide;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg    <= x;
            prod_reg <= PW'(x) * PW'(lsdr_pkg::DIV10_MUL);
        end
    end

    assign quot     = XW'(prod_reg >> lsdr_pkg::DIV10_SHIFT);
    // The remainder is below ten, so only the low bits of the difference matter.
    assign rem_wide = (XW + 4)'(x_reg) - (XW + 4)'(quot) * (XW + 4)'(lsdr_pkg::RADIX);
    assign digit    = rem_wide[lsdr_pkg::DIGIT_W-1:0];

endmodule

`default_nettype wire
